// ----- rtl/line_segment_window_clipper_top_defines.svh -----
// Assertion macros for the line segment window clipper.
// Used by line_segment_window_clipper_top; no other dependencies.
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_TOP_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define LSWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define LSWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lswc_pkg.sv -----
// Shared constants for the line segment window clipper.
// No dependencies.
`default_nettype none
package lswc_pkg;
	localparam int unsigned CFG_INDEX_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT   = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT  = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOP    = 8'd3;

	localparam int RST_LEFT   = 100;
	localparam int RST_RIGHT  = 700;
	localparam int RST_BOTTOM = 100;
	localparam int RST_TOP    = 500;

	localparam logic [3:0] OC_LEFT   = 4'd1;
	localparam logic [3:0] OC_RIGHT  = 4'd2;
	localparam logic [3:0] OC_BOTTOM = 4'd4;
	localparam logic [3:0] OC_TOP    = 4'd8;

	localparam logic [2:0] MAX_MOVES = 3'd4;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_PROD  = 3'd2;
	localparam logic [2:0] ST_DIVGO = 3'd3;
	localparam logic [2:0] ST_DIVW  = 3'd4;
endpackage
`default_nettype wire

// ----- rtl/lswc_div_cell.sv -----
// One restoring division step, registered; one quotient bit per cell.
// No package dependencies.
`default_nettype none
module lswc_div_cell #(
	parameter int WIDTH = 17
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [WIDTH-1:0] in_rem,
	input  wire logic [WIDTH-1:0] in_low,
	input  wire logic [WIDTH-1:0] in_quo,
	input  wire logic [WIDTH-1:0] in_div,
	output logic                  out_valid,
	output logic [WIDTH-1:0]      out_rem,
	output logic [WIDTH-1:0]      out_low,
	output logic [WIDTH-1:0]      out_quo,
	output logic [WIDTH-1:0]      out_div
);
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] rem_next;

	assign trial    = {in_rem, in_low[WIDTH-1]};
	assign diff     = trial - {1'b0, in_div};
	assign ge       = trial >= {1'b0, in_div};
	assign rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_rem <= rem_next;
		out_low <= {in_low[WIDTH-2:0], 1'b0};
		out_quo <= {in_quo[WIDTH-2:0], ge};
		out_div <= in_div;
	end
endmodule
`default_nettype wire

// ----- rtl/lswc_div_chain.sv -----
// Row of division cells: a 2*WIDTH-bit dividend whose quotient fits WIDTH bits.
// Depends on lswc_div_cell.
`default_nettype none
module lswc_div_chain #(
	parameter int WIDTH = 17
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [2*WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0]   divisor,
	output logic                    out_valid,
	output logic [WIDTH-1:0]        quotient
);
	logic             v_w   [0:WIDTH];
	logic [WIDTH-1:0] rem_w [0:WIDTH];
	logic [WIDTH-1:0] low_w [0:WIDTH];
	logic [WIDTH-1:0] quo_w [0:WIDTH];
	logic [WIDTH-1:0] div_w [0:WIDTH];

	// high half is already below the divisor when the quotient fits
	assign v_w[0]   = in_valid;
	assign rem_w[0] = dividend[2*WIDTH-1:WIDTH];
	assign low_w[0] = dividend[WIDTH-1:0];
	assign quo_w[0] = '0;
	assign div_w[0] = divisor;

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		lswc_div_cell #(.WIDTH(WIDTH)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_w[i]),
			.in_rem   (rem_w[i]),
			.in_low   (low_w[i]),
			.in_quo   (quo_w[i]),
			.in_div   (div_w[i]),
			.out_valid(v_w[i+1]),
			.out_rem  (rem_w[i+1]),
			.out_low  (low_w[i+1]),
			.out_quo  (quo_w[i+1]),
			.out_div  (div_w[i+1])
		);
	end

	assign out_valid = v_w[WIDTH];
	assign quotient  = quo_w[WIDTH];
endmodule
`default_nettype wire

// ----- rtl/line_segment_window_clipper_top.sv -----
// Cohen-Sutherland segment clipper; each boundary move runs through these steps:
// outcode and operand set-up, one product, then COORD_BITS+1 cells of the divider row.
// A segment needing k moves (k <= 4) gives its result once start is taken and all k
// moves are done; busy stays high until then, one item at a time.
// Results are strobed by done for one cycle and cannot be stalled.
// Reset restores the window to left 100, right 700, bottom 100, top 500; control clears.
`default_nettype none
`include "line_segment_window_clipper_top_defines.svh"
module line_segment_window_clipper_top
	import lswc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	output logic                              done,
	output logic                              accepted,
	output logic signed [COORD_BITS-1:0]      clipped_start_x,
	output logic signed [COORD_BITS-1:0]      clipped_start_y,
	output logic signed [COORD_BITS-1:0]      clipped_end_x,
	output logic signed [COORD_BITS-1:0]      clipped_end_y,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [COORD_BITS-1:0]        cfg_data
);
	localparam int DW = COORD_BITS + 1;

	logic [2:0] state_q;
	logic [2:0] moves_q;
	logic signed [COORD_BITS-1:0] left_q, right_q, bottom_q, top_q;
	logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;

	logic [3:0] c1, c2, co;
	logic signed [COORD_BITS-1:0] p0_c, bnd_c;
	logic signed [DW-1:0] d_c, n_c, m_c;
	logic horiz_c;

	logic [DW-1:0] magd_q, magn_q, magm_q;
	logic          neg_q, horiz_q, first_q;
	logic signed [COORD_BITS-1:0] p0_q, bnd_q;
	logic [2*DW-1:0] prod_q;

	logic          div_valid;
	logic [DW-1:0] div_quo;
	logic [COORD_BITS-1:0] q_c;
	logic signed [COORD_BITS-1:0] new_c;

	assign cfg_ready = 1'b1;
	assign busy      = state_q != ST_IDLE;

	always_comb begin
		c1 = '0;
		c2 = '0;
		if (x1_q < left_q) c1 |= OC_LEFT;
		else if (x1_q > right_q) c1 |= OC_RIGHT;
		if (y1_q < bottom_q) c1 |= OC_BOTTOM;
		else if (y1_q > top_q) c1 |= OC_TOP;
		if (x2_q < left_q) c2 |= OC_LEFT;
		else if (x2_q > right_q) c2 |= OC_RIGHT;
		if (y2_q < bottom_q) c2 |= OC_BOTTOM;
		else if (y2_q > top_q) c2 |= OC_TOP;
		co = (c1 != '0) ? c1 : c2;
	end

	// pick the boundary: top, bottom, right, left
	always_comb begin
		horiz_c = 1'b1;
		p0_c    = x1_q;
		d_c     = DW'(x2_q) - DW'(x1_q);
		m_c     = DW'(y2_q) - DW'(y1_q);
		if ((co & OC_TOP) != '0) begin
			bnd_c = top_q;
			n_c   = DW'(top_q) - DW'(y1_q);
		end else if ((co & OC_BOTTOM) != '0) begin
			bnd_c = bottom_q;
			n_c   = DW'(bottom_q) - DW'(y1_q);
		end else begin
			horiz_c = 1'b0;
			p0_c    = y1_q;
			d_c     = DW'(y2_q) - DW'(y1_q);
			m_c     = DW'(x2_q) - DW'(x1_q);
			if ((co & OC_RIGHT) != '0) begin
				bnd_c = right_q;
				n_c   = DW'(right_q) - DW'(x1_q);
			end else begin
				bnd_c = left_q;
				n_c   = DW'(left_q) - DW'(x1_q);
			end
		end
	end

	lswc_div_chain #(.WIDTH(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (state_q == ST_DIVGO),
		.dividend (prod_q),
		.divisor  (magm_q),
		.out_valid(div_valid),
		.quotient (div_quo)
	);

	assign q_c   = (magm_q == '0) ? '0 : div_quo[COORD_BITS-1:0];
	assign new_c = neg_q ? p0_q - $signed(q_c) : p0_q + $signed(q_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= COORD_BITS'(RST_LEFT);
			right_q  <= COORD_BITS'(RST_RIGHT);
			bottom_q <= COORD_BITS'(RST_BOTTOM);
			top_q    <= COORD_BITS'(RST_TOP);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			moves_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						moves_q <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if ((c1 == '0 && c2 == '0) || (c1 & c2) != '0 || moves_q == MAX_MOVES) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD:  state_q <= ST_DIVGO;
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_valid) begin
						moves_q <= moves_q + 3'd1;
						state_q <= ST_EVAL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x1_q <= start_x;
			y1_q <= start_y;
			x2_q <= end_x;
			y2_q <= end_y;
		end
		if (state_q == ST_EVAL) begin
			magd_q  <= d_c[DW-1] ? DW'(-d_c) : DW'(d_c);
			magn_q  <= n_c[DW-1] ? DW'(-n_c) : DW'(n_c);
			magm_q  <= m_c[DW-1] ? DW'(-m_c) : DW'(m_c);
			neg_q   <= d_c[DW-1] ^ n_c[DW-1] ^ m_c[DW-1];
			p0_q    <= p0_c;
			bnd_q   <= bnd_c;
			horiz_q <= horiz_c;
			first_q <= c1 != '0;
			accepted <= c1 == '0 && c2 == '0;
			// rejected segments report zero coordinates
			clipped_start_x <= (c1 == '0 && c2 == '0) ? x1_q : '0;
			clipped_start_y <= (c1 == '0 && c2 == '0) ? y1_q : '0;
			clipped_end_x   <= (c1 == '0 && c2 == '0) ? x2_q : '0;
			clipped_end_y   <= (c1 == '0 && c2 == '0) ? y2_q : '0;
		end
		if (state_q == ST_PROD) begin
			prod_q <= magd_q * magn_q;
		end
		if (state_q == ST_DIVW && div_valid) begin
			if (first_q) begin
				x1_q <= horiz_q ? new_c : bnd_q;
				y1_q <= horiz_q ? bnd_q : new_c;
			end else begin
				x2_q <= horiz_q ? new_c : bnd_q;
				y2_q <= horiz_q ? bnd_q : new_c;
			end
		end
	end

	`LSWC_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result strobed while still busy")
	`LSWC_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted item not taken up")
	`LSWC_ASSERT_NOW(a_moves_cap, clk, arst_n, busy, moves_q <= MAX_MOVES, "too many boundary moves")
	`LSWC_ASSERT_NOW(a_reject_zero, clk, arst_n, done && !accepted,
		clipped_start_x == '0 && clipped_end_y == '0, "rejected segment with nonzero coordinates")
endmodule
`default_nettype wire
